// File: rtl/core/mlvp_pkg.sv
package mlvp_pkg;

	// line parse phases, one-hot
	typedef enum logic [4:0] {
		PhLead  = 5'b00001,
		PhKey   = 5'b00010,
		PhGap   = 5'b00100,
		PhValue = 5'b01000,
		PhSkip  = 5'b10000
	} phase_t;

	// result status codes
	localparam logic [1:0] StOwn      = 2'd0;
	localparam logic [1:0] StFallback = 2'd1;
	localparam logic [1:0] StNone     = 2'd2;
	localparam logic [1:0] StEmpty    = 2'd3;

	// configuration register indexes
	localparam int        CfgIdxW         = 1;
	localparam logic [0:0] RegBoardName    = 1'd0;
	localparam logic [0:0] RegBoardNameLen = 1'd1;

	localparam int NameMax    = 8;
	localparam int MaxResults = 15;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0a;
	localparam logic [7:0] ChCr    = 8'h0d;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChHash  = 8'h23;
	localparam logic [7:0] ChStar  = 8'h2a;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       byte_valid;
		logic       end_of_body;
	} item_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic [3:0]                  length;
		logic [MaxResults-1:0][7:0] chars;
	} pick_t;

endpackage

// File: rtl/core/mlvp_if.sv
interface mlvp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       byte_valid;
	logic       end_of_body;

	modport source (output valid, byte_value, byte_valid, end_of_body, input ready);
	modport sink   (input valid, byte_value, byte_valid, end_of_body, output ready);
endinterface

interface mlvp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_status;
	logic [7:0] out_char;
	logic [3:0] out_length;
	logic       out_last;

	modport source (output valid, out_status, out_char, out_length, out_last, input ready);
	modport sink   (input valid, out_status, out_char, out_length, out_last, output ready);
endinterface

// File: rtl/core/mlvp_in_stage.sv
module mlvp_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	mlvp_byte_if.sink       text,
	input  logic            emit_busy,
	output logic            fire,
	output mlvp_pkg::item_t item
);

	logic            valid_s1;
	mlvp_pkg::item_t item_s1;

	// an end-of-body item waits until the emitter has drained
	assign fire       = valid_s1 && (!item_s1.end_of_body || !emit_busy);
	assign text.ready = !valid_s1 || fire;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1.byte_value  <= text.byte_value;
			item_s1.byte_valid  <= text.byte_valid;
			item_s1.end_of_body <= text.end_of_body;
		end
	end

endmodule

// File: rtl/core/mlvp_parser.sv
module mlvp_parser #(
	parameter int VALUE_CAP = 16,
	parameter int BODY_CAP  = 768
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  mlvp_pkg::item_t item,
	input  logic [63:0]     unit_key,
	input  logic [3:0]      unit_key_len,
	output logic            pick_load,
	output mlvp_pkg::pick_t pick
);

	localparam int StoreD = (VALUE_CAP - 1 < mlvp_pkg::MaxResults) ?
		VALUE_CAP - 1 : mlvp_pkg::MaxResults;
	localparam int VW = $clog2(VALUE_CAP + 1);
	localparam int TW = $clog2(VALUE_CAP);
	localparam int BW = $clog2(BODY_CAP);

	typedef struct packed {
		logic [3:0] len;
		logic       star;
		logic       board;
	} key_t;

	mlvp_pkg::phase_t phase_q, phase_d;
	key_t             key_q, key_d, key_step;
	logic [VW-1:0]    vpos_q, vpos_d, pos_v;
	logic [TW-1:0]    vtrim_q, vtrim_d, own_len_q, own_len_d, fb_len_q, fb_len_d;
	logic [TW-1:0]    own_len_m, fb_len_m, pick_len;
	logic             vlong_q, vlong_d;
	logic [BW-1:0]    bytes_q, bytes_d;

	logic [StoreD-1:0][7:0] value_buf_q, value_buf_d, own_buf_q, fb_buf_q;
	logic [StoreD-1:0][7:0] own_buf_m, fb_buf_m, src;

	logic [7:0] c;
	logic [3:0] bl;
	logic       take, blank, term, do_key, do_value, accept_line, store_own, store_fb;
	logic       doc_end;

	assign bl = (unit_key_len > 4'(mlvp_pkg::NameMax)) ?
		4'(mlvp_pkg::NameMax) : unit_key_len;

	// one key character against the board name; the key is all zero in the
	// leading-blank phase, so the first character starts at position zero
	always_comb begin
		key_step.star  = (key_q.len == '0) && (c == mlvp_pkg::ChStar);
		key_step.board = ((key_q.len == '0) || key_q.board) && (key_q.len < bl) &&
			(c == unit_key[8 * key_q.len[2:0] +: 8]);
		key_step.len   = (key_q.len >= 4'(mlvp_pkg::NameMax + 1)) ?
			4'(mlvp_pkg::NameMax + 1) : key_q.len + 4'd1;
	end

	always_comb begin
		phase_d     = phase_q;
		key_d       = key_q;
		vpos_d      = vpos_q;
		vtrim_d     = vtrim_q;
		vlong_d     = vlong_q;
		value_buf_d = value_buf_q;
		own_len_d   = own_len_q;
		fb_len_d    = fb_len_q;
		do_key      = 1'b0;
		do_value    = 1'b0;
		pos_v       = vpos_q;
		term        = 1'b0;
		doc_end     = fire && item.end_of_body;
		c           = item.byte_value;
		blank       = (c == mlvp_pkg::ChSpace) || (c == mlvp_pkg::ChTab);
		take        = fire && item.byte_valid && (bytes_q != BW'(BODY_CAP - 1));
		bytes_d     = take ? bytes_q + 1'b1 : bytes_q;

		if (take && c != mlvp_pkg::ChNul) begin
			if (c == mlvp_pkg::ChCr || c == mlvp_pkg::ChLf) begin
				term = 1'b1;
			end else begin
				case (phase_q)
					mlvp_pkg::PhLead: begin
						if (c == mlvp_pkg::ChHash) begin
							phase_d = mlvp_pkg::PhSkip;
						end else if (!blank) begin
							key_d.len = '0;
							do_key    = 1'b1;
							phase_d   = mlvp_pkg::PhKey;
						end
					end
					mlvp_pkg::PhKey: begin
						if (blank) phase_d = mlvp_pkg::PhGap;
						else do_key = 1'b1;
					end
					mlvp_pkg::PhGap: begin
						if (!blank) begin
							pos_v    = '0;
							vlong_d  = 1'b0;
							vtrim_d  = '0;
							do_value = 1'b1;
							phase_d  = mlvp_pkg::PhValue;
						end
					end
					mlvp_pkg::PhValue: do_value = 1'b1;
					default: ;
				endcase
			end
		end

		if (do_key) key_d = key_step;

		if (do_value) begin
			for (int i = 0; i < StoreD; i++) begin
				if (pos_v == VW'(i)) value_buf_d[i] = c;
			end
			if (!blank) begin
				if (pos_v >= VW'(VALUE_CAP - 1)) vlong_d = 1'b1;
				else vtrim_d = TW'(pos_v + 1'b1);
			end
			vpos_d = (pos_v >= VW'(VALUE_CAP)) ? VW'(VALUE_CAP) : pos_v + 1'b1;
		end

		if (doc_end) term = 1'b1;

		// close the line: commit the value to the matching slot
		accept_line = term && (phase_d == mlvp_pkg::PhValue) && (vtrim_d != '0) && !vlong_d;
		store_fb    = accept_line && key_d.star;
		store_own   = accept_line && !key_d.star && key_d.board && (key_d.len == bl);
		own_len_m   = store_own ? vtrim_d : own_len_q;
		fb_len_m    = store_fb ? vtrim_d : fb_len_q;
		own_len_d   = own_len_m;
		fb_len_d    = fb_len_m;

		if (term) begin
			phase_d = mlvp_pkg::PhLead;
			key_d   = '0;
			vpos_d  = '0;
			vtrim_d = '0;
			vlong_d = 1'b0;
		end

		if (doc_end) begin
			own_len_d = '0;
			fb_len_d  = '0;
			bytes_d   = '0;
		end
	end

	assign own_buf_m = store_own ? value_buf_d : own_buf_q;
	assign fb_buf_m  = store_fb ? value_buf_d : fb_buf_q;

	// end-of-body pick, own value before fallback
	always_comb begin
		pick_len    = '0;
		src         = own_buf_m;
		pick.chars  = '0;
		if (bytes_q == '0 && !take) begin
			pick.status = mlvp_pkg::StEmpty;
		end else if (own_len_m != '0) begin
			pick.status = mlvp_pkg::StOwn;
			pick_len    = own_len_m;
		end else if (fb_len_m != '0) begin
			pick.status = mlvp_pkg::StFallback;
			pick_len    = fb_len_m;
			src         = fb_buf_m;
		end else begin
			pick.status = mlvp_pkg::StNone;
		end
		pick.length = (int'(pick_len) > mlvp_pkg::MaxResults) ?
			4'(mlvp_pkg::MaxResults) : 4'(pick_len);
		for (int i = 0; i < StoreD; i++) pick.chars[i] = src[i];
	end

	assign pick_load = doc_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mlvp_pkg::PhLead;
			key_q     <= '0;
			vpos_q    <= '0;
			vtrim_q   <= '0;
			vlong_q   <= 1'b0;
			own_len_q <= '0;
			fb_len_q  <= '0;
			bytes_q   <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			key_q     <= key_d;
			vpos_q    <= vpos_d;
			vtrim_q   <= vtrim_d;
			vlong_q   <= vlong_d;
			own_len_q <= own_len_d;
			fb_len_q  <= fb_len_d;
			bytes_q   <= bytes_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			value_buf_q <= value_buf_d;
			own_buf_q   <= own_buf_m;
			fb_buf_q    <= fb_buf_m;
		end
	end

endmodule

// File: rtl/core/mlvp_emitter.sv
module mlvp_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  mlvp_pkg::pick_t pick,
	output logic            busy,
	mlvp_result_if.source   version
);

	logic                                  active_q;
	logic [3:0]                            idx_q;
	logic [1:0]                            status_q;
	logic [3:0]                            len_q;
	logic [mlvp_pkg::MaxResults-1:0][7:0] chars_q;
	logic                                  last;

	assign last               = (len_q == 4'd0) || (idx_q == len_q - 4'd1);
	assign busy               = active_q;
	assign version.valid      = active_q;
	assign version.out_status = status_q;
	assign version.out_length = len_q;
	assign version.out_char   = (len_q == 4'd0) ? 8'd0 : chars_q[idx_q];
	assign version.out_last   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (version.valid && version.ready) begin
			if (last) active_q <= 1'b0;
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= pick.status;
			len_q    <= pick.length;
			chars_q  <= pick.chars;
		end
	end

endmodule

// File: rtl/core/manifest_line_version_picker_top.sv
// Manifest line version picker.
// text channel: one manifest byte per transaction (byte_value, byte_valid,
// end_of_body). Bytes are parsed at one per cycle while no end_of_body item
// waits; CR/LF closes a line and "key value" lines for key '*' or the
// configured board name are kept. version channel: after an end_of_body
// transaction the picked value leaves as one transaction per character
// (1..15), or a single status-only transaction; out_last marks the final one
// of the run. A byte lands in the input register on its transaction and is
// parsed in the following cycle; an end_of_body item is parsed once the
// emitter is idle, and the pick is registered in the emitter before the
// first result is offered.
// The next document's bytes are taken while the burst drains; only its
// end_of_body transaction waits in the input register until the burst is
// done, which in turn holds text.ready low.
// Receiver stall: the emitter holds the current character; text keeps
// flowing until an end_of_body transaction reaches the input register.
// Reset (arst_n low) clears the board name, the line parser, the stored
// lengths and the byte count; no clearing pass is needed.
// Configuration (write_en/reg_index/write_data) only while the block is idle.
module manifest_line_version_picker_top #(
	parameter int VALUE_CAP = 16,
	parameter int BODY_CAP  = 768
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mlvp_byte_if.sink                     text,
	mlvp_result_if.source                 version,
	input  logic                          write_en,
	input  logic [mlvp_pkg::CfgIdxW-1:0] reg_index,
	input  logic [63:0]                   write_data
);

	logic [63:0]     unit_key_q;
	logic [3:0]      unit_key_len_q;
	logic            fire;
	logic            emit_busy;
	logic            pick_load;
	mlvp_pkg::item_t item;
	mlvp_pkg::pick_t pick;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_key_q     <= '0;
			unit_key_len_q <= '0;
		end else if (write_en) begin
			case (reg_index)
				mlvp_pkg::RegBoardName:    unit_key_q     <= write_data;
				mlvp_pkg::RegBoardNameLen: unit_key_len_q <= write_data[3:0];
				default: ;
			endcase
		end
	end

	// input register; an end item stalls here while a burst is in flight
	mlvp_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.emit_busy (emit_busy),
		.fire      (fire),
		.item      (item)
	);

	// line parse, value capture and end-of-body pick
	mlvp_parser #(
		.VALUE_CAP (VALUE_CAP),
		.BODY_CAP  (BODY_CAP)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.item         (item),
		.unit_key     (unit_key_q),
		.unit_key_len (unit_key_len_q),
		.pick_load    (pick_load),
		.pick         (pick)
	);

	// result register, one character per transaction
	mlvp_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (pick_load),
		.pick    (pick),
		.busy    (emit_busy),
		.version (version)
	);

	// a new pick never lands on a burst still in flight
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_body |-> !emit_busy)
		else $error("end of body parsed while emitter busy");

	// status-only results carry no characters and end the run
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		version.valid && (version.out_status == mlvp_pkg::StNone ||
		version.out_status == mlvp_pkg::StEmpty) |->
		version.out_last && version.out_length == 4'd0 && version.out_char == 8'd0)
		else $error("bad status-only result");

	// a picked value is never empty
	a_value_len: assert property (@(posedge clk) disable iff (!arst_n)
		version.valid && (version.out_status == mlvp_pkg::StOwn ||
		version.out_status == mlvp_pkg::StFallback) |-> version.out_length != 4'd0)
		else $error("picked value has zero length");

	// the last transaction of a burst closes it
	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		version.valid && version.ready && version.out_last |=> !version.valid)
		else $error("result offered after last transaction");

endmodule
